/* hdl/old_pkg.sv */
// Package for the object location directory: command and status codes,
// table sizing and the shared slot, mark and state types. No dependencies.
package old_pkg;

  localparam int TableDepth = 64;
  localparam int SlotBits   = $clog2(TableDepth);
  localparam int ServerBits = 16;

  typedef enum logic [2:0] {
    CMD_LOOKUP    = 3'd0,
    CMD_ADD_LOCAL = 3'd1,
    CMD_BEGIN_MIG = 3'd2,
    CMD_CREATE    = 3'd3,
    CMD_MOVE      = 3'd4,
    CMD_KILL      = 3'd5,
    CMD_ACK       = 3'd6,
    CMD_TICK      = 3'd7
  } command_t;

  typedef enum logic [2:0] {
    ST_FOUND     = 3'd0,
    ST_TRANSIT   = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_DONE      = 3'd3,
    ST_FULL      = 3'd4,
    ST_FINISHED  = 3'd5,
    ST_NONE      = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DECIDE, S_TICK, S_OUT
  } state_t;

  // Payload words of one slot as held in the slot memory.
  typedef struct packed {
    logic [63:0]           key_high;
    logic [63:0]           key_low;
    logic [ServerBits-1:0] owner_server;
    logic [ServerBits-1:0] transit_dest;
    logic [ServerBits-1:0] finished_from;
  } slot_t;

  typedef struct packed {
    logic        owned;
    logic        transit;
    logic        finished;
  } marks_t;

endpackage

/* hdl/old_in_if.sv */
// Input channel of the object location directory.
// Depends on nothing but carries the command word fields.
interface old_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [63:0] object_id_high;
  logic [63:0] object_id_low;
  logic [15:0] target_server;
  logic [15:0] source_server;
  modport source (output valid, command, object_id_high, object_id_low, target_server,
                  source_server, input ready);
  modport sink (input valid, command, object_id_high, object_id_low, target_server,
                source_server, output ready);
endinterface

/* hdl/old_out_if.sv */
// Result channel of the object location directory.
// Depends on nothing.
interface old_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] server_out;
  logic [63:0] result_id_high;
  logic [63:0] result_id_low;
  logic        last;
  modport source (output valid, status, server_out, result_id_high, result_id_low, last,
                  input ready);
  modport sink (input valid, status, server_out, result_id_high, result_id_low, last,
                output ready);
endinterface

/* hdl/object_location_directory_unit.sv */
// Top level of the object location directory: slot memory, mark flops and
// the command sequencer. Depends on old_pkg, old_in_if and old_out_if.
//
//   channel   direction  word
//   in        sink       command, object id, target and source server
//   out       source     status, server_out, result id, last
//   cfg       write      host_server_id (16 bits)
//
// Each command scans the slot memory one slot a cycle; a new word is taken only
// in S_IDLE, after the scan, decide (not for a tick) and output steps. A tick
// emits one word per finished slot, the last as the closing word after its scan,
// or one ST_NONE word if none is. The marks reset to clear at once, so no
// clearing pass follows reset. Output stalls hold S_OUT, or halt the tick scan
// when a second finished slot turns up before the previous word has left.
module object_location_directory_unit (
  input  logic        clk,
  input  logic        rst,
  old_in_if.sink      in,
  old_out_if.source   out,
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  localparam int SB = old_pkg::SlotBits;
  localparam int VB = old_pkg::ServerBits;

  logic [VB-1:0] host_server_id;
  always_ff @(posedge clk) begin
    if (rst) host_server_id <= '0;
    else if (cfg_we) host_server_id <= cfg_wdata[VB-1:0];
  end

  old_pkg::marks_t marks [old_pkg::TableDepth];
  old_pkg::slot_t  mem   [old_pkg::TableDepth];
  old_pkg::slot_t  rd_data;

  old_pkg::state_t state, state_next;
  logic [SB:0]     addr;      // scan address, one bit wider to hold the depth
  logic [SB-1:0]   rd_idx;    // slot index matching rd_data
  logic            rd_vld;
  old_pkg::command_t cmd;
  logic [63:0]     key_high, key_low;
  logic [VB-1:0]   target, source;
  logic            hit, have_free;
  logic [SB-1:0]   hit_idx, free_idx;
  old_pkg::slot_t  hit_slot;
  logic            pend_vld;
  old_pkg::slot_t  pend_slot;

  logic [2:0]  o_status;
  logic [15:0] o_server;
  logic [63:0] o_hi, o_lo;
  logic        o_last;

  // Memory access: one read per cycle during scans unless a tick scan stalls, one write at decide.
  logic            mem_we;
  old_pkg::slot_t  mem_wdata;
  logic [SB-1:0]   mem_waddr;
  logic            rd_en;

  old_pkg::marks_t rd_mk, hm;
  logic rd_used, rd_match, rd_fin, scan_end, out_free;
  logic tick_stall, tick_emit, out_load;

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (rd_en) rd_data <= mem[addr[SB-1:0]];
  end

  assign rd_mk    = marks[rd_idx];
  assign hm       = marks[hit_idx];
  assign out_free = !out.valid || out.ready;
  assign rd_used  = rd_vld && (rd_mk.owned || rd_mk.transit || rd_mk.finished);
  assign rd_match = rd_used && rd_data.key_high == key_high && rd_data.key_low == key_low;
  assign rd_fin   = rd_vld && rd_mk.finished;
  assign scan_end = addr == (SB+1)'(old_pkg::TableDepth);

  // A finished slot found while an earlier one still waits must hold the
  // scan until the earlier word can go to the output register.
  assign tick_stall = (state == old_pkg::S_TICK) && rd_fin && pend_vld && !out_free;
  assign tick_emit  = (state == old_pkg::S_TICK) && rd_fin && pend_vld && out_free;
  assign out_load   = tick_emit || ((state == old_pkg::S_OUT) && out_free);
  assign rd_en      = (state == old_pkg::S_SCAN) || ((state == old_pkg::S_TICK) && !tick_stall);

  assign in.ready = (state == old_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      old_pkg::S_IDLE:   if (in.valid) state_next = (in.command == old_pkg::CMD_TICK)
                           ? old_pkg::S_TICK : old_pkg::S_SCAN;
      old_pkg::S_SCAN:   if (scan_end && !rd_vld) state_next = old_pkg::S_DECIDE;
      old_pkg::S_DECIDE: state_next = old_pkg::S_OUT;
      old_pkg::S_TICK:   if (scan_end && !rd_vld) state_next = old_pkg::S_OUT;
      old_pkg::S_OUT:    if (out_free) state_next = old_pkg::S_IDLE;
      default:           state_next = old_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = hit ? hit_idx : free_idx;
    mem_wdata = hit_slot;
    if (state == old_pkg::S_DECIDE) begin
      case (cmd)
        old_pkg::CMD_ADD_LOCAL, old_pkg::CMD_CREATE, old_pkg::CMD_MOVE: begin
          mem_we = hit || have_free;
          if (!hit) begin
            mem_wdata.key_high = key_high;
            mem_wdata.key_low  = key_low;
          end
          mem_wdata.owner_server = target;
        end
        old_pkg::CMD_BEGIN_MIG: begin
          mem_we = hit && hm.owned && (hit_slot.owner_server == host_server_id);
          mem_wdata.transit_dest = target;
        end
        old_pkg::CMD_ACK: begin
          mem_we = hit && hm.transit;
          mem_wdata.finished_from = source;
        end
        default: mem_we = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out.valid <= 1'b0;
    else if (out_load) out.valid <= 1'b1;
    else if (out.ready) out.valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (tick_emit) begin
      out.status         <= old_pkg::ST_FINISHED;
      out.server_out     <= 16'(pend_slot.finished_from);
      out.result_id_high <= pend_slot.key_high;
      out.result_id_low  <= pend_slot.key_low;
      out.last           <= 1'b0;
    end else if (out_load) begin
      out.status         <= o_status;
      out.server_out     <= o_server;
      out.result_id_high <= o_hi;
      out.result_id_low  <= o_lo;
      out.last           <= o_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= old_pkg::S_IDLE;
      rd_vld   <= 1'b0;
      pend_vld <= 1'b0;
      for (int i = 0; i < old_pkg::TableDepth; i++) marks[i] <= '0;
    end else begin
      state <= state_next;
      case (state)
        old_pkg::S_IDLE: begin
          addr      <= '0;
          rd_vld    <= 1'b0;
          hit       <= 1'b0;
          have_free <= 1'b0;
          pend_vld  <= 1'b0;
          if (in.valid) begin
            cmd      <= old_pkg::command_t'(in.command);
            key_high <= in.object_id_high;
            key_low  <= in.object_id_low;
            target   <= in.target_server[VB-1:0];
            source   <= in.source_server[VB-1:0];
          end
        end
        old_pkg::S_SCAN: begin
          if (!scan_end) addr <= addr + 1'b1;
          rd_vld <= !scan_end;
          rd_idx <= addr[SB-1:0];
          // Keep a copy of the matching slot for the write-back at decide.
          if (rd_match) begin
            hit      <= 1'b1;
            hit_idx  <= rd_idx;
            hit_slot <= rd_data;
          end
          if (rd_vld && !rd_used && !have_free) begin
            have_free <= 1'b1;
            free_idx  <= rd_idx;
          end
        end
        old_pkg::S_DECIDE: begin
          o_server <= '0; o_hi <= '0; o_lo <= '0; o_last <= 1'b1;
          o_status <= old_pkg::ST_DONE;
          case (cmd)
            old_pkg::CMD_LOOKUP:
              if (hit && hm.transit) o_status <= old_pkg::ST_TRANSIT;
              else if (hit && hm.owned) begin
                o_status <= old_pkg::ST_FOUND;
                o_server <= 16'(hit_slot.owner_server);
              end else o_status <= old_pkg::ST_NOT_FOUND;
            old_pkg::CMD_ADD_LOCAL, old_pkg::CMD_CREATE, old_pkg::CMD_MOVE:
              if (hit) marks[hit_idx].owned <= 1'b1;
              else if (have_free) marks[free_idx].owned <= 1'b1;
              else o_status <= old_pkg::ST_FULL;
            old_pkg::CMD_BEGIN_MIG:
              if (hit && hm.owned && hit_slot.owner_server == host_server_id)
                marks[hit_idx].transit <= 1'b1;
            old_pkg::CMD_KILL:
              if (hit) marks[hit_idx].owned <= 1'b0;
            old_pkg::CMD_ACK:
              if (hit && hm.transit) begin
                marks[hit_idx].transit  <= 1'b0;
                marks[hit_idx].finished <= 1'b1;
              end
            default: o_status <= old_pkg::ST_DONE;
          endcase
        end
        old_pkg::S_TICK: begin
          if (!tick_stall) begin
            if (!scan_end) addr <= addr + 1'b1;
            rd_vld <= !scan_end;
            rd_idx <= addr[SB-1:0];
            if (rd_fin) begin
              marks[rd_idx].finished <= 1'b0;
              pend_vld  <= 1'b1;
              pend_slot <= rd_data;
            end
          end
          // The slot still pending at the end of the scan is the closing word.
          if (scan_end && !rd_vld) begin
            o_last <= 1'b1;
            if (pend_vld) begin
              o_status <= old_pkg::ST_FINISHED;
              o_server <= 16'(pend_slot.finished_from);
              o_hi     <= pend_slot.key_high;
              o_lo     <= pend_slot.key_low;
            end else begin
              o_status <= old_pkg::ST_NONE;
              o_server <= '0;
              o_hi     <= '0;
              o_lo     <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule
